// ===== hw/rtl/bsmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmm_pkg
// Shared types and constants for the bank-switch memory mapper: mode flag
// positions, target codes, register indexes and the decoded result record.
// ----------------------------------------------------------------------------
package bsmm_pkg;

  // Mode register layout
  localparam int unsigned ModeW       = 12;
  localparam int unsigned MWrite      = 0;   // language card write enable
  localparam int unsigned MRdSame     = 1;   // read select, compared with write enable
  localparam int unsigned MBank1      = 3;
  localparam int unsigned MAltZp      = 4;
  localparam int unsigned MRdAux      = 5;
  localparam int unsigned MWrAux      = 6;
  localparam int unsigned MIntCx      = 7;
  localparam int unsigned MSlotC3     = 8;
  localparam int unsigned M80Store    = 9;
  localparam int unsigned MPage2      = 10;
  localparam int unsigned MIntC8      = 11;

  localparam logic [ModeW-1:0] ModeReset = 12'h001;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgOlderMachine = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMemoryTest   = 2'd1;

  // Decoded target codes
  typedef enum logic [3:0] {
    TGT_RAM     = 4'd0,
    TGT_ROM     = 4'd1,
    TGT_KEY     = 4'd2,
    TGT_KEYST   = 4'd3,
    TGT_SLOTIO  = 4'd4,
    TGT_SLOTROM = 4'd5,
    TGT_JOY     = 4'd6,
    TGT_FLOAT   = 4'd7,
    TGT_ZERO    = 4'd8,
    TGT_VIDST   = 4'd9,
    TGT_NONE    = 4'd10
  } target_t;

  // Bus access kind
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // One decoded access
  typedef struct packed {
    target_t     target;
    logic [16:0] location;
    logic        status_bit;
    logic        video_write;
    logic        video_aux;
    logic        video_switch;
    logic        speaker_toggle;
    logic        joystick_strobe;
    logic [7:0]  data_out;
  } result_t;

  // Buffered bus access
  typedef struct packed {
    logic        opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        hires_on;
  } access_t;

endpackage

// ===== hw/rtl/bsmm_decode.sv =====
// ----------------------------------------------------------------------------
// bsmm_decode
// Combinational decode of one bus access against the current mode register:
// target, physical location, status bit, side pulses and next mode value.
// ----------------------------------------------------------------------------
module bsmm_decode import bsmm_pkg::*; (
  input  access_t          acc,
  input  logic [ModeW-1:0] mode,
  input  logic             older_machine,
  input  logic             memory_test,
  output result_t          res,
  output logic [ModeW-1:0] mode_nxt
);

  logic [15:0] a;
  logic [7:0]  hi8;
  logic [3:0]  page;
  logic [3:0]  io;
  logic [3:0]  lo;
  logic        page1;
  logic        store80;
  logic        lc_ram;
  logic        lc_aux;
  logic [16:0] lc_loc;
  logic [16:0] rom_off;
  logic [16:0] dev_loc;
  logic        vid_area;
  logic        page_vs;
  logic        mstat;

  assign a    = acc.address;
  assign hi8  = a[15:8];
  assign page = a[15:12];
  assign io   = a[7:4];
  assign lo   = a[3:0];

  // Shared address terms
  assign page1   = (a < 16'h0800) || (a >= 16'h2000 && a < 16'h4000);
  assign store80 = !older_machine && mode[M80Store] && page1 && (a >= 16'h0400)
                   && ((a < 16'h0800) || acc.hires_on);
  assign lc_ram  = (mode[MWrite] == mode[MRdSame]);
  assign lc_aux  = mode[MAltZp] && !older_machine;
  assign lc_loc  = (page == 4'hD && mode[MBank1]) ? {lc_aux, 4'hC, a[11:0]}
                                                  : {lc_aux, a};
  // Only used for addresses at or above $C000
  assign rom_off = {3'b000, a[13:0]};
  assign dev_loc = {9'd0, a[7:0]};
  assign vid_area = (a >= 16'h0400 && a < 16'h0C00) || (a >= 16'h2000 && a < 16'h6000);
  assign page_vs  = !older_machine || (a < 16'hC05E);

  // Memory soft-switch status
  always_comb begin
    case (lo)
      4'h1:    mstat = !mode[MBank1];
      4'h2:    mstat = lc_ram;
      4'h3:    mstat = mode[MRdAux];
      4'h4:    mstat = mode[MWrAux];
      4'h5:    mstat = mode[MIntCx];
      4'h6:    mstat = mode[MAltZp];
      4'h7:    mstat = mode[MSlotC3];
      4'h8:    mstat = mode[M80Store];
      default: mstat = 1'b0;
    endcase
  end

  // Main decode
  always_comb begin
    res          = '0;
    res.target   = TGT_NONE;
    res.data_out = (acc.opcode == OpWrite) ? acc.write_data : 8'd0;
    mode_nxt     = mode;

    if (acc.opcode == OpRead) begin
      if (store80) begin
        res.target   = TGT_RAM;
        res.location = {mode[MPage2], a};
      end else if (hi8 <= 8'h01) begin
        res.target   = TGT_RAM;
        res.location = {mode[MAltZp], a};
      end else if (hi8 == 8'hC0) begin
        res.target = TGT_FLOAT;
        if (memory_test) begin
          res.target = TGT_ZERO;
        end else begin
          case (io)
            4'h0: begin
              res.target   = TGT_KEY;
              res.location = dev_loc;
            end
            4'h1: begin
              res.location = dev_loc;
              if (lo >= 4'h9) begin
                res.target = TGT_VIDST;
              end else begin
                res.target     = TGT_KEYST;
                res.status_bit = mstat;
              end
            end
            4'h3: res.speaker_toggle = 1'b1;
            4'h5: begin
              if (a == 16'hC054) mode_nxt[MPage2] = 1'b0;
              else if (a == 16'hC055) mode_nxt[MPage2] = 1'b1;
              res.video_switch = page_vs;
            end
            4'h6: begin
              res.target   = TGT_JOY;
              res.location = dev_loc;
            end
            4'h7: res.joystick_strobe = (a == 16'hC070);
            4'h8: mode_nxt[3:0] = lo;
            4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF: begin
              res.target   = TGT_SLOTIO;
              res.location = dev_loc;
            end
            default: ;
          endcase
        end
      end else if (hi8 == 8'hC3) begin
        if (mode[MSlotC3] || older_machine) begin
          res.target   = TGT_SLOTROM;
          res.location = {5'd0, a[11:0]};
        end else begin
          mode_nxt[MIntC8] = 1'b1;
          res.target       = TGT_ROM;
          res.location     = rom_off;
        end
      end else if (hi8 >= 8'hC1 && hi8 <= 8'hC7) begin
        if (!mode[MIntCx] || older_machine) begin
          res.target   = TGT_SLOTROM;
          res.location = {5'd0, a[11:0]};
        end else begin
          res.target   = TGT_ROM;
          res.location = rom_off;
        end
      end else if (page == 4'hC) begin
        if ((!mode[MIntCx] && !mode[MIntC8]) || older_machine) begin
          res.target = TGT_FLOAT;
        end else begin
          if (a == 16'hCFFF) mode_nxt[MIntC8] = 1'b0;
          res.target   = TGT_ROM;
          res.location = rom_off;
        end
      end else if (page < 4'hC) begin
        res.target   = TGT_RAM;
        res.location = {mode[MRdAux], a};
      end else if (lc_ram) begin
        res.target   = TGT_RAM;
        res.location = lc_loc;
      end else begin
        res.target   = TGT_ROM;
        res.location = rom_off;
      end
    end else begin
      if (vid_area) begin
        res.target      = TGT_RAM;
        res.video_write = 1'b1;
        if (store80) begin
          res.location  = {mode[MPage2], a};
          res.video_aux = mode[MPage2];
        end else begin
          res.location  = {mode[MWrAux], a};
          res.video_aux = mode[MWrAux];
        end
      end else if (hi8 <= 8'h01) begin
        res.target   = TGT_RAM;
        res.location = {mode[MAltZp], a};
      end else if (hi8 == 8'hC0) begin
        case (io)
          4'h0, 4'h1: begin
            // Aux and ROM soft switches sit at $C000-$C00B; $C00C-$C00F are video switches
            if (io == 4'h0 && !older_machine) begin
              if (lo >= 4'hC) begin
                res.video_switch = 1'b1;
              end else begin
                case (lo[3:1])
                  3'd0:    mode_nxt[M80Store] = lo[0];
                  3'd1:    mode_nxt[MRdAux]   = lo[0];
                  3'd2:    mode_nxt[MWrAux]   = lo[0];
                  3'd3:    mode_nxt[MIntCx]   = lo[0];
                  3'd4:    mode_nxt[MAltZp]   = lo[0];
                  default: mode_nxt[MSlotC3]  = lo[0];
                endcase
                res.video_switch = (lo <= 4'h1);
              end
            end
            res.target   = TGT_KEY;
            res.location = dev_loc;
          end
          4'h3: res.speaker_toggle = 1'b1;
          4'h5: begin
            if (a == 16'hC054) mode_nxt[MPage2] = 1'b0;
            else if (a == 16'hC055) mode_nxt[MPage2] = 1'b1;
            res.video_switch = page_vs;
          end
          4'h7: res.joystick_strobe = (a == 16'hC070);
          4'h8: mode_nxt[3:0] = lo;
          4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF: begin
            res.target   = TGT_SLOTIO;
            res.location = dev_loc;
          end
          default: ;
        endcase
      end else if (hi8 == 8'hC3) begin
        if (mode[MSlotC3] || older_machine) begin
          res.target   = TGT_SLOTROM;
          res.location = {5'd0, a[11:0]};
        end else begin
          mode_nxt[MIntC8] = 1'b1;
        end
      end else if (hi8 >= 8'hC1 && hi8 <= 8'hC7) begin
        if (!mode[MIntCx] || older_machine) begin
          res.target   = TGT_SLOTROM;
          res.location = {5'd0, a[11:0]};
        end
      end else if (page == 4'hC) begin
        if (a == 16'hCFFF) mode_nxt[MIntC8] = 1'b0;
      end else if (page < 4'hC) begin
        res.target   = TGT_RAM;
        res.location = {mode[MWrAux], a};
      end else if (mode[MWrite]) begin
        res.target   = TGT_RAM;
        res.location = lc_loc;
      end
    end
  end

endmodule

// ===== hw/rtl/bank_switch_memory_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// bank_switch_memory_mapper_unit
// Language card and aux memory bank-switch decoder for an 8-bit CPU bus.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one CPU bus access per item. in_tuser = opcode (0 read, 1 write).
//           in_tdata = address, write_data, hires_on, zero padding.
//   out_* : one decoded result per access. out_tuser = target code.
//           out_tdata = location, status_bit, video pulses, speaker,
//           joystick strobe, data_out, zero padding.
//   cfg_* : register writes (index 0 older_machine, 1 memory_test), always
//           ready; write only while no access is in flight.
// Pipeline: two register stages. An accepted item is held in the input
// register and is then decoded into the output register, which raises
// out_tvalid. Throughput is one item per cycle while out_tready holds; the
// mode register is updated as each item moves into the output register, so
// the next item decodes against the new mode.
// A stalled receiver holds the output register; one more item waits in the
// input register before in_tready drops.
// Reset clears both pipeline stages and the config bits and sets the mode
// register to write enable only.
// ----------------------------------------------------------------------------
module bank_switch_memory_mapper_unit import bsmm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // [15:0] address, [23:16] write_data,
                                         // [24] hires_on, [31:25] zero
  input  logic               in_tuser,   // [0] opcode
  // Result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,  // [16:0] location, [17] status_bit,
                                         // [18] video_write, [19] video_aux,
                                         // [20] video_switch, [21] speaker_toggle,
                                         // [22] joystick_strobe, [30:23] data_out,
                                         // [31] zero
  output logic [3:0]         out_tuser,  // [3:0] target
  // Configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic               cfg_data
);

  logic             s1_valid_r;
  access_t          s1_acc_r;
  logic             out_valid_r;
  result_t          out_res_r;
  logic [ModeW-1:0] mode_r;
  logic [ModeW-1:0] mode_nxt;
  logic             older_r;
  logic             mtest_r;
  result_t          dec_res;
  logic             advance;
  logic             s1_load;

  // Handshake control
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign s1_load   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Decode
  bsmm_decode u_decode (
    .acc           (s1_acc_r),
    .mode          (mode_r),
    .older_machine (older_r),
    .memory_test   (mtest_r),
    .res           (dec_res),
    .mode_nxt      (mode_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_acc_r.opcode     <= in_tuser;
      s1_acc_r.address    <= in_tdata[15:0];
      s1_acc_r.write_data <= in_tdata[23:16];
      s1_acc_r.hires_on   <= in_tdata[24];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  // Mode register follows each item into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeReset;
    end else if (advance && s1_valid_r) begin
      mode_r <= mode_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= 1'b0;
      mtest_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgOlderMachine) older_r <= cfg_data;
      if (cfg_index == CfgMemoryTest)   mtest_r <= cfg_data;
    end
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {1'b0,
                       out_res_r.data_out,
                       out_res_r.joystick_strobe,
                       out_res_r.speaker_toggle,
                       out_res_r.video_switch,
                       out_res_r.video_aux,
                       out_res_r.video_write,
                       out_res_r.status_bit,
                       out_res_r.location};

endmodule

// ===== tb/tb_bank_switch_memory_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bank_switch_memory_mapper_unit
// Self-checking bench for the bank-switch memory mapper. Bus access items
// are sent on the input stream while a local decoder model works out each
// result and keeps its own copy of the mode register. Results are checked
// field by field, in order. The bench covers directed soft-switch and
// mapping cases, then random traffic under every register setting, with
// idling on both sides.
// ----------------------------------------------------------------------------
module tb_bank_switch_memory_mapper_unit import bsmm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [16:0] AuxBase = 17'h10000;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;
  logic [3:0]         out_tuser;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic               cfg_data   = 1'b0;

  // Decoder model state
  logic [ModeW-1:0] mode_m;
  logic             older_m;
  logic             memtest_m;

  result_t expected_decodes[$];
  int      fail_count     = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  bank_switch_memory_mapper_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Language card physical address, bank 1 folds $Dxxx down to $Cxxx
  function automatic logic [16:0] lc_addr(input logic [15:0] a);
    logic [16:0] aux;
    aux = (mode_m[MAltZp] && !older_m) ? AuxBase : '0;
    if (a[15:12] == 4'hD && mode_m[MBank1])
      return 17'h0C000 + {5'd0, a[11:0]} + aux;
    return {1'b0, a} + aux;
  endfunction

  // Decode one access and apply its soft-switch effects to the mode copy
  function automatic result_t predict_decode(input logic op, input logic [15:0] a,
                                             input logic [7:0] d, input logic hires);
    result_t     r;
    logic [7:0]  hi8;
    logic [3:0]  pg, io, lo;
    logic        page1, store80, vid, lc_ram;
    logic [16:0] p2aux, zpaux, wraux, rdaux;
    hi8 = a[15:8];
    pg  = a[15:12];
    io  = a[7:4];
    lo  = a[3:0];
    r = '0;
    r.target = TGT_NONE;
    lc_ram  = (mode_m[MWrite] == mode_m[MRdSame]);
    page1   = (a < 16'h0800) || (a >= 16'h2000 && a < 16'h4000);
    store80 = !older_m && mode_m[M80Store] && page1 && a >= 16'h0400 &&
              (a < 16'h0800 || hires);
    p2aux = mode_m[MPage2] ? AuxBase : '0;
    zpaux = mode_m[MAltZp] ? AuxBase : '0;
    wraux = mode_m[MWrAux] ? AuxBase : '0;
    rdaux = mode_m[MRdAux] ? AuxBase : '0;

    if (op == OpRead) begin
      if (store80) begin
        r.target = TGT_RAM; r.location = {1'b0, a} + p2aux;
      end else if (hi8 <= 8'h01) begin
        r.target = TGT_RAM; r.location = {1'b0, a} + zpaux;
      end else if (hi8 == 8'hC0) begin
        r.target = TGT_FLOAT;
        if (memtest_m) begin
          r.target = TGT_ZERO;
        end else begin
          case (io)
            4'h0: begin
              r.target = TGT_KEY; r.location = {9'd0, a[7:0]};
            end
            4'h1: begin
              r.location = {9'd0, a[7:0]};
              if (lo >= 4'h9) begin
                r.target = TGT_VIDST;
              end else begin
                r.target = TGT_KEYST;
                case (lo)
                  4'h1: r.status_bit = !mode_m[MBank1];
                  4'h2: r.status_bit = lc_ram;
                  4'h3: r.status_bit = mode_m[MRdAux];
                  4'h4: r.status_bit = mode_m[MWrAux];
                  4'h5: r.status_bit = mode_m[MIntCx];
                  4'h6: r.status_bit = mode_m[MAltZp];
                  4'h7: r.status_bit = mode_m[MSlotC3];
                  4'h8: r.status_bit = mode_m[M80Store];
                  default: r.status_bit = 1'b0;
                endcase
              end
            end
            4'h3: r.speaker_toggle = 1'b1;
            4'h5: begin
              if (a == 16'hC054) mode_m[MPage2] = 1'b0;
              else if (a == 16'hC055) mode_m[MPage2] = 1'b1;
              if (!older_m || a < 16'hC05E) r.video_switch = 1'b1;
            end
            4'h6: begin
              r.target = TGT_JOY; r.location = {9'd0, a[7:0]};
            end
            4'h7: r.joystick_strobe = (a == 16'hC070);
            4'h8: mode_m[3:0] = lo;
            default: begin
              if (io >= 4'h9) begin
                r.target = TGT_SLOTIO; r.location = {9'd0, a[7:0]};
              end
            end
          endcase
        end
      end else if (hi8 == 8'hC3) begin
        if (mode_m[MSlotC3] || older_m) begin
          r.target = TGT_SLOTROM; r.location = {5'd0, a[11:0]};
        end else begin
          mode_m[MIntC8] = 1'b1;
          r.target = TGT_ROM; r.location = {1'b0, a} - 17'h0C000;
        end
      end else if (hi8 >= 8'hC1 && hi8 <= 8'hC7) begin
        if (!mode_m[MIntCx] || older_m) begin
          r.target = TGT_SLOTROM; r.location = {5'd0, a[11:0]};
        end else begin
          r.target = TGT_ROM; r.location = {1'b0, a} - 17'h0C000;
        end
      end else if (pg == 4'hC) begin
        if ((!mode_m[MIntCx] && !mode_m[MIntC8]) || older_m) begin
          r.target = TGT_FLOAT;
        end else begin
          if (a == 16'hCFFF) mode_m[MIntC8] = 1'b0;
          r.target = TGT_ROM; r.location = {1'b0, a} - 17'h0C000;
        end
      end else if (pg < 4'hC) begin
        r.target = TGT_RAM; r.location = {1'b0, a} + rdaux;
      end else if (lc_ram) begin
        r.target = TGT_RAM; r.location = lc_addr(a);
      end else begin
        r.target = TGT_ROM; r.location = {1'b0, a} - 17'h0C000;
      end
    end else begin
      vid = (a >= 16'h0400 && a < 16'h0C00) || (a >= 16'h2000 && a < 16'h6000);
      if (vid) begin
        r.target = TGT_RAM;
        r.video_write = 1'b1;
        if (store80) begin
          r.location = {1'b0, a} + p2aux; r.video_aux = mode_m[MPage2];
        end else begin
          r.location = {1'b0, a} + wraux; r.video_aux = mode_m[MWrAux];
        end
      end else if (hi8 <= 8'h01) begin
        r.target = TGT_RAM; r.location = {1'b0, a} + zpaux;
      end else if (hi8 == 8'hC0) begin
        case (io)
          4'h0, 4'h1: begin
            // Aux memory switches: even address clears, odd sets
            if (io == 4'h0 && !older_m) begin
              if (lo >= 4'hC) begin
                r.video_switch = 1'b1;
              end else begin
                case (lo[3:1])
                  3'd0: mode_m[M80Store] = lo[0];
                  3'd1: mode_m[MRdAux]   = lo[0];
                  3'd2: mode_m[MWrAux]   = lo[0];
                  3'd3: mode_m[MIntCx]   = lo[0];
                  3'd4: mode_m[MAltZp]   = lo[0];
                  default: mode_m[MSlotC3] = lo[0];
                endcase
                if (lo <= 4'h1) r.video_switch = 1'b1;
              end
            end
            r.target = TGT_KEY; r.location = {9'd0, a[7:0]};
          end
          4'h3: r.speaker_toggle = 1'b1;
          4'h5: begin
            if (a == 16'hC054) mode_m[MPage2] = 1'b0;
            else if (a == 16'hC055) mode_m[MPage2] = 1'b1;
            if (!older_m || a < 16'hC05E) r.video_switch = 1'b1;
          end
          4'h7: r.joystick_strobe = (a == 16'hC070);
          4'h8: mode_m[3:0] = lo;
          default: begin
            if (io >= 4'h9) begin
              r.target = TGT_SLOTIO; r.location = {9'd0, a[7:0]};
            end
          end
        endcase
      end else if (hi8 == 8'hC3) begin
        if (mode_m[MSlotC3] || older_m) begin
          r.target = TGT_SLOTROM; r.location = {5'd0, a[11:0]};
        end else begin
          mode_m[MIntC8] = 1'b1;
        end
      end else if (hi8 >= 8'hC1 && hi8 <= 8'hC7) begin
        if (!mode_m[MIntCx] || older_m) begin
          r.target = TGT_SLOTROM; r.location = {5'd0, a[11:0]};
        end
      end else if (pg == 4'hC) begin
        if (a == 16'hCFFF) mode_m[MIntC8] = 1'b0;
      end else if (pg < 4'hC) begin
        r.target = TGT_RAM; r.location = {1'b0, a} + wraux;
      end else if (mode_m[MWrite]) begin
        r.target = TGT_RAM; r.location = lc_addr(a);
      end
      r.data_out = d;
    end
    return r;
  endfunction

  // Random access, weighted towards the I/O page and bank-switched areas
  function automatic access_t random_access();
    access_t     acc;
    int unsigned pick;
    acc.opcode     = 1'($urandom_range(0, 1));
    acc.write_data = 8'($urandom_range(0, 255));
    acc.hires_on   = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      acc.address[15:8] = 8'hC0;
      acc.address[7:0]  = 8'($urandom_range(0, 255));
    end else if (pick < 45) begin
      acc.address[15:8] = 8'hC0;
      acc.address[7:4]  = 4'($urandom_range(0, 8));
      acc.address[3:0]  = 4'($urandom_range(0, 15));
    end else if (pick < 55) acc.address = 16'($urandom_range(16'hC100, 16'hCFFF));
    else if (pick < 58) acc.address = 16'hCFFF;
    else if (pick < 70) acc.address = 16'($urandom_range(16'hD000, 16'hFFFF));
    else if (pick < 80) acc.address = 16'($urandom_range(16'h0000, 16'h0BFF));
    else if (pick < 87) acc.address = 16'($urandom_range(16'h2000, 16'h5FFF));
    else acc.address = 16'($urandom_range(0, 16'hFFFF));
    return acc;
  endfunction

  // Send one access item; valid stays high into the next item unless it idles
  task automatic send_access(input logic op, input logic [15:0] addr,
                             input logic [7:0] d, input logic hires);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, hires, d, addr};
    do @(posedge clk); while (!in_tready);
    expected_decodes.push_back(predict_decode(op, addr, d, hires));
  endtask

  // Stop sending and wait for every outstanding result, then settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic val);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgOlderMachine) older_m = val;
    else if (idx == CfgMemoryTest) memtest_m = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls
  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Result checker
  always @(posedge clk) begin : check_results
    result_t act, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      act.target          = target_t'(out_tuser);
      act.location        = out_tdata[16:0];
      act.status_bit      = out_tdata[17];
      act.video_write     = out_tdata[18];
      act.video_aux       = out_tdata[19];
      act.video_switch    = out_tdata[20];
      act.speaker_toggle  = out_tdata[21];
      act.joystick_strobe = out_tdata[22];
      act.data_out        = out_tdata[30:23];
      if (expected_decodes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result item with nothing expected, tgt %0d loc %h",
                   $realtime, act.target, act.location);
      end else begin
        exp_r = expected_decodes.pop_front();
        if (act !== exp_r) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: mismatch exp tgt %0d loc %h st %b vw %b va %b vs %b spk %b joy %b d %h",
                     $realtime, exp_r.target, exp_r.location, exp_r.status_bit,
                     exp_r.video_write, exp_r.video_aux, exp_r.video_switch,
                     exp_r.speaker_toggle, exp_r.joystick_strobe, exp_r.data_out);
            $display("%0t:          got tgt %0d loc %h st %b vw %b va %b vs %b spk %b joy %b d %h",
                     $realtime, act.target, act.location, act.status_bit,
                     act.video_write, act.video_aux, act.video_switch,
                     act.speaker_toggle, act.joystick_strobe, act.data_out);
          end
        end
      end
    end
  end

  // Mapping and soft-switch corners on the newer model
  task automatic test_directed_decode();
    send_access(OpRead,  16'h0000, 8'h00, 1'b0);  // zero page, main
    send_access(OpWrite, 16'hFFFF, 8'hFF, 1'b1);  // write-enabled LC RAM
    send_access(OpRead,  16'hC080, 8'h00, 1'b0);  // LC: read RAM, no write
    send_access(OpWrite, 16'hD000, 8'hA5, 1'b0);  // protected write dropped
    send_access(OpRead,  16'hC012, 8'h00, 1'b0);  // LC read-RAM status
    send_access(OpRead,  16'hC01F, 8'h00, 1'b0);  // video status
    send_access(OpRead,  16'hC08B, 8'h00, 1'b0);  // bank 1, read+write RAM
    send_access(OpRead,  16'hD123, 8'h00, 1'b0);  // bank 1 folds to $Cxxx
    send_access(OpRead,  16'hC011, 8'h00, 1'b0);  // bank status
    send_access(OpWrite, 16'hC009, 8'h5A, 1'b0);  // alternate zero page on
    send_access(OpRead,  16'h00FF, 8'h00, 1'b1);  // zero page in aux
    send_access(OpRead,  16'hE000, 8'h00, 1'b0);  // LC RAM in aux bank
    send_access(OpRead,  16'hC3FF, 8'h00, 1'b0);  // internal C3 ROM sets latch
    send_access(OpRead,  16'hC800, 8'h00, 1'b0);  // expansion ROM via latch
    send_access(OpRead,  16'hCFFF, 8'h00, 1'b0);  // clears latch
    send_access(OpRead,  16'hC800, 8'h00, 1'b0);  // floating bus now
    send_access(OpWrite, 16'hC001, 8'h00, 1'b0);  // 80STORE on
    send_access(OpRead,  16'hC055, 8'h00, 1'b0);  // page 2
    send_access(OpWrite, 16'h2000, 8'h3C, 1'b1);  // hires page via 80STORE
    send_access(OpRead,  16'hC030, 8'h00, 1'b0);  // speaker
    send_access(OpRead,  16'hC070, 8'h00, 1'b0);  // joystick strobe
    send_access(OpRead,  16'hC064, 8'h00, 1'b0);  // joystick read
    send_access(OpWrite, 16'hC0F0, 8'h81, 1'b0);  // slot I/O
    send_access(OpWrite, 16'hC00D, 8'h00, 1'b0);  // video switch, no mode bit
    send_access(OpRead,  16'hC020, 8'h00, 1'b0);  // unused I/O floats
  endtask

  // Older model and memory test switches at their extremes
  task automatic test_config_extremes();
    write_register(CfgOlderMachine, 1'b1);
    send_access(OpWrite, 16'hC007, 8'h00, 1'b0);  // no mode change
    send_access(OpRead,  16'hC105, 8'h00, 1'b0);  // slot ROM always
    send_access(OpRead,  16'hC05F, 8'h00, 1'b0);  // video switch suppressed
    send_access(OpRead,  16'hF000, 8'h00, 1'b0);  // LC without aux bank
    send_access(OpRead,  16'h0010, 8'h00, 1'b0);  // zero page still aux
    write_register(CfgMemoryTest, 1'b1);
    send_access(OpRead,  16'hC000, 8'h00, 1'b0);  // I/O reads give zero
    send_access(OpRead,  16'hC08F, 8'h00, 1'b0);  // switch suppressed too
    write_register(CfgOlderMachine, 1'b0);
    write_register(CfgMemoryTest, 1'b0);
  endtask

  // Random traffic over every setting and idling pattern
  task automatic test_random_traffic();
    access_t acc;
    int      sel;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 34 : (ph == 1) ? 54 : 0;
      recv_stall_pct = (ph == 0) ? 54 : (ph == 1) ? 34 : 0;
      for (int c = 0; c < 5; c++) begin
        sel = c % 4;
        write_register(CfgOlderMachine, sel[1]);
        write_register(CfgMemoryTest, sel[0]);
        for (int n = 0; n < 72; n++) begin
          // hold off until the pipeline has fully drained
          if (n == 36) wait_idle();
          acc = random_access();
          send_access(acc.opcode, acc.address, acc.write_data, acc.hires_on);
        end
      end
    end
  endtask

  initial begin
    mode_m    = ModeReset;
    older_m   = 1'b0;
    memtest_m = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 34;
    recv_stall_pct = 54;
    test_directed_decode();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_decodes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
